@@ hw/rtl/jsu_pkg.sv @@
// Shared types, character codes and UTF-8 helpers for the JSON string unescape unit.
// No dependencies; the decoder, result register, top unit and bench import it.
package jsu_pkg;

   localparam int MAX_RESULTS = 6;

   typedef enum logic [3:0] {
      MODE_NORMAL        = 4'd0,
      MODE_ESC           = 4'd1,
      MODE_HEX           = 4'd2,
      MODE_AFTER_HIGH    = 4'd3,
      MODE_AFTER_HIGH_BS = 4'd4,
      MODE_HEX2          = 4'd5,
      MODE_DRAIN         = 4'd6,
      MODE_DRAIN_ESC     = 4'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_UNTERMINATED = 3'd1,
      ST_TRUNC_ESC    = 3'd2,
      ST_UNKNOWN_ESC  = 3'd3,
      ST_BAD_UNICODE  = 3'd4
   } status_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;

   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_TAB = 8'h09;

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

   // Decoded results of one input byte: data bytes first, then optional end result.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [2:0]                  ndata;
      logic                        has_end;
      status_type                  status;
   } burst_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic utf8_type cp_to_utf8(input logic [20:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = {1'b0, cp[6:0]};
         r.len      = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
         r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
         r.len      = 3'd2;
      end else if (cp < CP_SUPP_BASE) begin
         r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
         r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
         r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
         r.len      = 3'd3;
      end else begin
         r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
         r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
         r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
         r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
         r.len      = 3'd4;
      end
      return r;
   endfunction

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (c >= CH_0 && c <= CH_9) begin
         r.val = 4'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LF) begin
         r.val = 4'(c - CH_LA + 8'd10);
      end else if (c >= CH_UA && c <= CH_UF) begin
         r.val = 4'(c - CH_UA + 8'd10);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/jsu_req_if.sv @@
// Input channel of the JSON string unescape unit: one raw body byte per transaction.
// Depends on nothing but the handshake convention valid/ready.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ hw/rtl/jsu_rsp_if.sv @@
// Result channel of the JSON string unescape unit: one decoded byte or end status
// per transaction. Depends on nothing but the handshake convention valid/ready.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       string_end;
   logic [2:0] status;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output string_end,
                   output status, output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input string_end,
                   input status, input last, output ready);
endinterface

@@ hw/rtl/jsu_decode.sv @@
// Escape decoder: holds the decode state and turns one raw byte into a burst of results.
// Depends on jsu_pkg.
module jsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         in_byte,
   input  logic               end_of_input,
   output jsu_pkg::burst_type burst
);
   import jsu_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  pend_ff, pend_in;
   status_type  err_ff, err_in;

   hex_type     hd;
   logic [15:0] acc_shift;
   logic        do_escape, do_normal, do_code, do_drain;
   logic        pre_fffd, main_raw, main_cp, close;
   logic [7:0]  raw_byte;
   logic [20:0] cp;
   utf8_type    fffd_enc, main_enc;
   logic [2:0]  main_len;

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      err_in    = err_ff;
      do_escape = 1'b0;
      do_normal = 1'b0;
      do_code   = 1'b0;
      do_drain  = 1'b0;
      pre_fffd  = 1'b0;
      main_raw  = 1'b0;
      main_cp   = 1'b0;
      close     = 1'b0;
      raw_byte  = in_byte;
      cp        = '0;
      hd        = hex_decode(in_byte);
      acc_shift = {acc_ff[11:0], hd.val};

      unique case (mode_ff)
         MODE_ESC: begin
            do_escape = 1'b1;
         end
         MODE_HEX, MODE_HEX2: begin
            if (!hd.ok) begin
               err_in   = ST_BAD_UNICODE;
               do_drain = 1'b1;
            end else begin
               acc_in = acc_shift;
               if (cnt_ff != 2'd3) begin
                  cnt_in = cnt_ff + 2'd1;
               end else begin
                  cnt_in = 2'd0;
                  if (mode_ff == MODE_HEX) begin
                     do_code = 1'b1;
                  end else if (acc_shift >= LOW_SURR_LO && acc_shift <= LOW_SURR_HI) begin
                     main_cp = 1'b1;
                     cp      = CP_SUPP_BASE + {1'b0, pend_ff, acc_shift[9:0]};
                     mode_in = MODE_NORMAL;
                  end else begin
                     pre_fffd = 1'b1;
                     do_code  = 1'b1;
                  end
               end
            end
         end
         MODE_AFTER_HIGH: begin
            if (in_byte == CH_BSLASH) begin
               mode_in = MODE_AFTER_HIGH_BS;
            end else begin
               pre_fffd  = 1'b1;
               do_normal = 1'b1;
            end
         end
         MODE_AFTER_HIGH_BS: begin
            if (in_byte == CH_U) begin
               acc_in  = '0;
               cnt_in  = 2'd0;
               mode_in = MODE_HEX2;
            end else begin
               pre_fffd  = 1'b1;
               do_escape = 1'b1;
            end
         end
         MODE_DRAIN: begin
            do_drain = 1'b1;
         end
         MODE_DRAIN_ESC: begin
            mode_in = MODE_DRAIN;
         end
         default: begin
            do_normal = 1'b1;
         end
      endcase

      // complete \u value standing on its own
      if (do_code) begin
         if (acc_shift >= HIGH_SURR_LO && acc_shift <= HIGH_SURR_HI) begin
            pend_in = acc_shift[9:0];
            mode_in = MODE_AFTER_HIGH;
         end else begin
            main_cp = 1'b1;
            cp      = (acc_shift >= LOW_SURR_LO && acc_shift <= LOW_SURR_HI) ?
                      CP_REPLACE : {5'b00000, acc_shift};
            mode_in = MODE_NORMAL;
         end
      end

      if (do_escape) begin
         mode_in  = MODE_NORMAL;
         main_raw = 1'b1;
         unique case (in_byte)
            CH_QUOTE:  raw_byte = CH_QUOTE;
            CH_BSLASH: raw_byte = CH_BSLASH;
            CH_SLASH:  raw_byte = CH_SLASH;
            CH_B:      raw_byte = CTL_BS;
            CH_F:      raw_byte = CTL_FF;
            CH_N:      raw_byte = CTL_LF;
            CH_R:      raw_byte = CTL_CR;
            CH_T:      raw_byte = CTL_TAB;
            CH_U: begin
               main_raw = 1'b0;
               acc_in   = '0;
               cnt_in   = 2'd0;
               mode_in  = MODE_HEX;
            end
            default: begin
               main_raw = 1'b0;
               err_in   = ST_UNKNOWN_ESC;
               mode_in  = MODE_DRAIN;
            end
         endcase
      end

      if (do_normal) begin
         if (in_byte == CH_QUOTE) begin
            close = 1'b1;
         end else if (in_byte == CH_BSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            main_raw = 1'b1;
            mode_in  = MODE_NORMAL;
         end
      end

      if (do_drain) begin
         if (in_byte == CH_QUOTE) begin
            close = 1'b1;
         end else if (in_byte == CH_BSLASH) begin
            mode_in = MODE_DRAIN_ESC;
         end else begin
            mode_in = MODE_DRAIN;
         end
      end

      // pack the burst: optional U+FFFD first, then the main character
      fffd_enc = cp_to_utf8(CP_REPLACE);
      main_enc = cp_to_utf8(cp);
      if (main_raw) begin
         main_enc.bytes    = '0;
         main_enc.bytes[0] = raw_byte;
         main_enc.len      = 3'd1;
      end
      main_len = (main_raw || main_cp) ? main_enc.len : 3'd0;

      burst.data    = '0;
      burst.has_end = 1'b0;
      burst.status  = ST_OK;
      if (pre_fffd) begin
         burst.data[0] = fffd_enc.bytes[0];
         burst.data[1] = fffd_enc.bytes[1];
         burst.data[2] = fffd_enc.bytes[2];
         burst.ndata   = 3'd3 + main_len;
      end else begin
         burst.ndata   = main_len;
      end
      for (int j = 0; j < 4; j++) begin
         if (3'(j) < main_len) begin
            if (pre_fffd) begin
               if (j < 3) begin
                  burst.data[j+3] = main_enc.bytes[j];
               end
            end else begin
               burst.data[j] = main_enc.bytes[j];
            end
         end
      end

      if (close) begin
         burst.has_end = 1'b1;
         burst.status  = err_in;
      end else if (end_of_input) begin
         burst.ndata   = 3'd0;
         burst.has_end = 1'b1;
         burst.status  = (mode_in == MODE_ESC || mode_in == MODE_AFTER_HIGH_BS ||
                          mode_in == MODE_DRAIN_ESC) ? ST_TRUNC_ESC : ST_UNTERMINATED;
      end

      if (burst.has_end) begin
         mode_in = MODE_NORMAL;
         acc_in  = '0;
         cnt_in  = 2'd0;
         pend_in = '0;
         err_in  = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         acc_ff  <= '0;
         cnt_ff  <= 2'd0;
         pend_ff <= '0;
         err_ff  <= ST_OK;
      end else if (take) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
         err_ff  <= err_in;
      end
   end

endmodule

@@ hw/rtl/jsu_burst.sv @@
// Result register: holds one burst of up to six results, sent one per cycle on ready.
// Depends on jsu_pkg and jsu_rsp_if.
module jsu_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_pkg::burst_type burst_in,
   output logic               can_load,
   jsu_rsp_if.source          rsp_if
);
   import jsu_pkg::*;

   logic [MAX_RESULTS-1:0][7:0] data_ff;
   logic [2:0]                  ndata_ff;
   status_type                  status_ff;
   logic [2:0]                  total_ff, total_in;
   logic [2:0]                  ptr_ff, ptr_in;
   logic                        is_data, is_last, fire;

   assign is_data  = ptr_ff < ndata_ff;
   assign is_last  = 3'(ptr_ff + 3'd1) == total_ff;
   assign fire     = rsp_if.valid && rsp_if.ready;
   assign can_load = !rsp_if.valid || (fire && is_last);

   assign rsp_if.valid      = ptr_ff != total_ff;
   assign rsp_if.out_byte   = is_data ? data_ff[ptr_ff] : 8'h00;
   assign rsp_if.byte_valid = is_data;
   assign rsp_if.string_end = !is_data;
   assign rsp_if.status     = is_data ? ST_OK : status_ff;
   assign rsp_if.last       = is_last;

   always_comb begin
      ptr_in   = ptr_ff;
      total_in = total_ff;
      if (load) begin
         ptr_in   = 3'd0;
         total_in = burst_in.ndata + {2'b00, burst_in.has_end};
      end else if (fire) begin
         ptr_in = ptr_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= 3'd0;
         total_ff <= 3'd0;
      end else begin
         ptr_ff   <= ptr_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= burst_in.data;
         ndata_ff  <= burst_in.ndata;
         status_ff <= burst_in.status;
      end
   end

endmodule

@@ hw/rtl/json_string_unescape_utf8_unit.sv @@
// JSON string unescape unit. Feed the body bytes of a JSON string literal (after the
// opening quote), one per req transaction; the unit returns the decoded UTF-8 bytes
// on rsp, then one end transaction (string_end=1) carrying the final status, and
// marks the last result of each input byte with last. A byte yields zero to six
// results: plain bytes and simple escapes give one, \u escapes give one to four
// (a joined surrogate pair gives four, a stray surrogate gives U+FFFD), an unpaired
// high surrogate followed by another \u escape can give six. A byte is taken at the
// same clock edge at which the previous byte's last result leaves (or at once if the
// result register is empty), so a byte holds the unit until its last result leaves;
// one-result bytes run at one byte per cycle while rsp is ready, and bytes with no
// result (backslash, hex digits) leave the register empty. The six-entry result
// register and its read pointer set this pace. There is no clearing pass after
// reset. On a non-zero final status the consumer must drop the string's bytes; the
// unit does not. Depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_decode, jsu_burst.
module json_string_unescape_utf8_unit (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_if,
   jsu_rsp_if.source rsp_if
);
   import jsu_pkg::*;

   burst_type burst;
   logic      can_load;
   logic      take;

   // accept a new byte when the result register is empty or its last result is leaving
   assign req_if.ready = can_load;
   assign take         = req_if.valid && can_load;

   // decode state advances only on an accepted transaction
   jsu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .in_byte      (req_if.in_byte),
      .end_of_input (req_if.end_of_input),
      .burst        (burst)
   );

   // hold the burst and send it out one result per cycle while rsp is ready
   jsu_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .burst_in (burst),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

   // a new byte is taken only when no earlier result would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> (!rsp_if.valid || (rsp_if.ready && rsp_if.last)))
      else $error("input accepted while results still pending");

   // the end result always closes the burst of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.string_end) |-> rsp_if.last)
      else $error("string end result not marked last");

   // data results carry no status and are never end results
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.byte_valid) |-> (!rsp_if.string_end && rsp_if.status == ST_OK))
      else $error("data result with end flag or status");

   // a pending burst holds while the consumer stalls
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_if.out_byte)
                                            && $stable(rsp_if.last)))
      else $error("result changed while stalled");

endmodule

@@ verif/tb_json_string_unescape_utf8_unit.sv @@
// Self-checking bench for json_string_unescape_utf8_unit: drives string body bytes on req,
// decodes them in a behavioral model and compares every rsp transaction field by field.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if and the unit itself.
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_unit;
   import jsu_pkg::*;

   localparam int RANDOM_BYTES   = 240;  // random stimulus stops after about this many bytes
   localparam int CALM_BYTES     = 80;   // the closing stretch runs without idle bursts
   localparam int LONG_HOLD      = 150;  // one long rsp back-pressure stretch, in cycles
   localparam int DRAIN_CYCLES   = 16;   // settle time after the last result
   localparam int WATCHDOG_LIMIT = 3000; // cycles with no transaction on either side

   // One decoded result as it appears on rsp.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_end;
      status_type status;
      logic       last;
   } result_type;

   // One row of the directed script; typed rows carry their one result written out.
   typedef struct {
      logic [7:0] in_byte;
      logic       eoi;
      logic       typed;
      result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape_utf8_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #6 clock = ~clock;

   // Decoder state mirrored in the bench.
   mode_type    dec_mode;
   logic [15:0] hex_acc;
   logic [1:0]  hex_cnt;
   logic [9:0]  high_pend;
   status_type  held_err;

   result_type   byte_results[$];  // results caused by the byte being decoded
   result_type   utf8_out_q[$];    // decoded results still owed by the unit
   stim_row_type directed_rows[$];

   // Idle and pressure controls set by the stimulus; the rsp side reads the last two.
   logic sender_idle   = 1'b0;
   logic sink_idle     = 1'b0;
   logic hold_pending  = 1'b0;

   int bytes_sent     = 0;
   int results_seen   = 0;
   int strings_closed = 0;
   int strings_failed = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   // ---------------------------------------------------------------------------------
   // Behavioral decoder
   // ---------------------------------------------------------------------------------

   function automatic void clear_decoder();
      dec_mode  = MODE_NORMAL;
      hex_acc   = '0;
      hex_cnt   = '0;
      high_pend = '0;
      held_err  = ST_OK;
   endfunction

   function automatic void emit_data(input logic [7:0] b);
      if (byte_results.size() < MAX_RESULTS)
         byte_results.push_back('{b, 1'b1, 1'b0, ST_OK, 1'b0});
   endfunction

   // Encode one code point as UTF-8, one result per byte.
   function automatic void emit_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         emit_data(cp[7:0]);
      end else if (cp < 21'h800) begin
         emit_data(UTF8_LEAD2 | {3'b000, cp[10:6]});
         emit_data(UTF8_CONT | {2'b00, cp[5:0]});
      end else if (cp < CP_SUPP_BASE) begin
         emit_data(UTF8_LEAD3 | {4'b0000, cp[15:12]});
         emit_data(UTF8_CONT | {2'b00, cp[11:6]});
         emit_data(UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
         emit_data(UTF8_LEAD4 | {5'b00000, cp[20:18]});
         emit_data(UTF8_CONT | {2'b00, cp[17:12]});
         emit_data(UTF8_CONT | {2'b00, cp[11:6]});
         emit_data(UTF8_CONT | {2'b00, cp[5:0]});
      end
   endfunction

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   // A complete four-digit value with no high surrogate waiting in front of it.
   function automatic void take_code(input logic [15:0] v);
      if (v >= HIGH_SURR_LO && v <= HIGH_SURR_HI) begin
         high_pend = v[9:0];
         dec_mode  = MODE_AFTER_HIGH;
      end else begin
         emit_code_point((v >= LOW_SURR_LO && v <= LOW_SURR_HI) ? CP_REPLACE : 21'(v));
         dec_mode = MODE_NORMAL;
      end
   endfunction

   // The byte that follows a backslash.
   function automatic void take_escape(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         CH_QUOTE:  v = CH_QUOTE;
         CH_BSLASH: v = CH_BSLASH;
         CH_SLASH:  v = CH_SLASH;
         CH_B:      v = CTL_BS;
         CH_F:      v = CTL_FF;
         CH_N:      v = CTL_LF;
         CH_R:      v = CTL_CR;
         CH_T:      v = CTL_TAB;
         CH_U: begin
            hex_acc  = '0;
            hex_cnt  = '0;
            dec_mode = MODE_HEX;
            return;
         end
         default: begin
            held_err = ST_UNKNOWN_ESC;
            dec_mode = MODE_DRAIN;
            return;
         end
      endcase
      emit_data(v);
      dec_mode = MODE_NORMAL;
   endfunction

   // Advance the decoder by one byte; returns 1 when the byte is the closing quote.
   function automatic logic consume_byte(input logic [7:0] c);
      logic again;
      logic closed;
      int   h;
      closed = 1'b0;
      do begin
         again = 1'b0;
         case (dec_mode)
            MODE_ESC: take_escape(c);
            MODE_HEX, MODE_HEX2: begin
               h = hex_digit(c);
               if (h < 0) begin
                  // a bad digit is held as an error, then the byte is taken again in drain mode
                  held_err = ST_BAD_UNICODE;
                  dec_mode = MODE_DRAIN;
                  again    = 1'b1;
               end else begin
                  hex_acc = {hex_acc[11:0], h[3:0]};
                  if (hex_cnt != 2'd3) begin
                     hex_cnt++;
                  end else begin
                     hex_cnt = '0;
                     if (dec_mode == MODE_HEX) begin
                        take_code(hex_acc);
                     end else if (hex_acc >= LOW_SURR_LO && hex_acc <= LOW_SURR_HI) begin
                        emit_code_point(CP_SUPP_BASE + 21'({high_pend, hex_acc[9:0]}));
                        dec_mode = MODE_NORMAL;
                     end else begin
                        emit_code_point(CP_REPLACE);
                        take_code(hex_acc);
                     end
                  end
               end
            end
            MODE_AFTER_HIGH: begin
               if (c == CH_BSLASH) begin
                  dec_mode = MODE_AFTER_HIGH_BS;
               end else begin
                  emit_code_point(CP_REPLACE);
                  dec_mode = MODE_NORMAL;
                  again    = 1'b1;
               end
            end
            MODE_AFTER_HIGH_BS: begin
               if (c == CH_U) begin
                  hex_acc  = '0;
                  hex_cnt  = '0;
                  dec_mode = MODE_HEX2;
               end else begin
                  emit_code_point(CP_REPLACE);
                  take_escape(c);
               end
            end
            MODE_DRAIN: begin
               if (c == CH_QUOTE) closed = 1'b1;
               else if (c == CH_BSLASH) dec_mode = MODE_DRAIN_ESC;
            end
            MODE_DRAIN_ESC: dec_mode = MODE_DRAIN;
            default: begin
               if (c == CH_QUOTE) begin
                  closed = 1'b1;
               end else if (c == CH_BSLASH) begin
                  dec_mode = MODE_ESC;
               end else begin
                  emit_data(c);
                  dec_mode = MODE_NORMAL;
               end
            end
         endcase
      end while (again);
      return closed;
   endfunction

   // Work out every result one input byte causes, last flag included.
   function automatic void unescape_byte(input logic [7:0] c, input logic eoi);
      status_type st;
      byte_results.delete();
      if (consume_byte(c)) begin
         byte_results.push_back('{8'h00, 1'b0, 1'b1, held_err, 1'b0});
         clear_decoder();
      end else if (eoi) begin
         // frame ended inside the string: drop the data, report the cut
         st = (dec_mode == MODE_ESC || dec_mode == MODE_AFTER_HIGH_BS ||
               dec_mode == MODE_DRAIN_ESC) ? ST_TRUNC_ESC : ST_UNTERMINATED;
         byte_results.delete();
         byte_results.push_back('{8'h00, 1'b0, 1'b1, st, 1'b0});
         clear_decoder();
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return CH_0 + 8'(n);
      return (upper ? CH_UA : CH_LA) + 8'(n - 4'd10);
   endfunction

   function automatic result_type data_rsp(input logic [7:0] b);
      return '{b, 1'b1, 1'b0, ST_OK, 1'b1};
   endfunction

   function automatic result_type end_rsp(input status_type st);
      return '{8'h00, 1'b0, 1'b1, st, 1'b1};
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic eoi, input logic typed,
                                   input result_type want);
      stim_row_type r;
      r.in_byte = b;
      r.eoi     = eoi;
      r.typed   = typed;
      r.want    = want;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_u_rows(input logic [15:0] v, input logic upper);
      add_row(CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CH_U, 1'b0, 1'b0, '0);
      for (int i = 3; i >= 0; i--) add_row(hex_char(v[i*4 +: 4], upper), 1'b0, 1'b0, '0);
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      // keep structure bytes out of plain text; they come through escapes and noise
      if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
      return b;
   endfunction

   function automatic logic [7:0] pick_escape_letter();
      case ($urandom_range(0, 7))
         0:       return CH_QUOTE;
         1:       return CH_BSLASH;
         2:       return CH_SLASH;
         3:       return CH_B;
         4:       return CH_F;
         5:       return CH_N;
         6:       return CH_R;
         default: return CH_T;
      endcase
   endfunction

   // Code values weighted toward UTF-8 length boundaries and surrogates.
   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 'h7F));
         1: return 16'($urandom_range('h80, 'h7FF));
         2: return 16'($urandom_range('h800, 'hFFFF));
         3: return 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
         4: return 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
         default: begin
            case ($urandom_range(0, 5))
               0:       return 16'h0000;
               1:       return 16'hFFFF;
               2:       return HIGH_SURR_LO;
               3:       return HIGH_SURR_HI;
               4:       return LOW_SURR_LO;
               default: return LOW_SURR_HI;
            endcase
         end
      endcase
   endfunction

   // Offer one byte on req, hold it until accepted, then book its results.
   task automatic send_byte(input logic [7:0] b, input logic eoi, input logic typed,
                            input result_type want);
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.in_byte      <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      unescape_byte(b, eoi);
      if (typed) utf8_out_q.push_back(want);
      else foreach (byte_results[i]) utf8_out_q.push_back(byte_results[i]);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Body byte of a random string; now and then the frame is cut right here.
   task automatic send_body(input logic [7:0] b);
      send_byte(b, $urandom_range(0, 59) == 0, 1'b0, '0);
   endtask

   task automatic send_u(input logic [15:0] v);
      send_body(CH_BSLASH);
      send_body(CH_U);
      for (int i = 3; i >= 0; i--) send_body(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
   endtask

   // One mostly well-formed string body with random content and a random ending.
   task automatic send_random_string();
      int         pick;
      int         ndig;
      logic [7:0] b;
      repeat ($urandom_range(0, 8)) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_body(plain_byte());
         end else if (pick < 50) begin
            send_body(CH_BSLASH);
            send_body(pick_escape_letter());
         end else if (pick < 65) begin
            send_u(pick_code());
         end else if (pick < 77) begin
            // proper surrogate pair
            send_u(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
            send_u(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)));
         end else if (pick < 88) begin
            // high surrogate followed by something that may not pair with it
            send_u(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
            case ($urandom_range(0, 3))
               0: send_u(pick_code());
               1: begin
                  send_body(CH_BSLASH);
                  send_body(pick_escape_letter());
               end
               2: send_body(plain_byte());
               default: send_u(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
            endcase
         end else if (pick < 94) begin
            // backslash with any byte, mostly an unknown escape
            send_body(CH_BSLASH);
            send_body(8'($urandom_range(0, 255)));
         end else begin
            // \u escape broken by a non-hex byte
            send_body(CH_BSLASH);
            send_body(CH_U);
            ndig = $urandom_range(0, 3);
            repeat (ndig) send_body(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
            send_body(b);
         end
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         send_body(CH_QUOTE);
      end else if (pick < 16) begin
         send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end else if (pick < 17) begin
         send_byte(CH_BSLASH, 1'b1, 1'b0, '0);
      end else begin
         // raw noise, any byte and occasional frame ends, then a quote
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, '0);
         send_byte(CH_QUOTE, 1'b0, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // rsp side: ready with random stall bursts and one long hold-off
   // ---------------------------------------------------------------------------------

   initial begin : result_ready_drive
      int unsigned stall_left;
      bit          hold_taken;
      stall_left   = 0;
      hold_taken   = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && hold_pending && !hold_taken) begin
            // hold off long enough for the unit to fill and stall req
            stall_left = LONG_HOLD;
            hold_taken = 1'b1;
         end else if (stall_left == 0 && sink_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Checking: every rsp transaction against the oldest owed result
   // ---------------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         if (rsp_ch.string_end === 1'b1) begin
            strings_closed++;
            if (rsp_ch.status !== ST_OK) strings_failed++;
         end
         if (utf8_out_q.size() == 0) begin
            $error("unexpected result: out_byte %h string_end %b status %0d",
                   rsp_ch.out_byte, rsp_ch.string_end, rsp_ch.status);
            mismatches++;
         end else begin
            want = utf8_out_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_ch.out_byte);
            check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_ch.byte_valid));
            check_field("string_end", 8'(want.string_end), 8'(rsp_ch.string_end));
            check_field("status", 8'(want.status), 8'(rsp_ch.status));
            check_field("last", 8'(want.last), 8'(rsp_ch.last));
         end
      end
   end

   // Stop a hung run: count cycles in which neither side moves a transaction.
   always @(posedge clock) begin : watchdog
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", quiet_cycles);
         $display("json_string_unescape_utf8_unit: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------

   initial begin : stimulus
      int directed_count;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.in_byte      = 8'h00;
      req_ch.end_of_input = 1'b0;
      clear_decoder();

      // Directed script: byte extremes, a joined pair at the top of the code space,
      // a high surrogate followed by a non-low \u (the six-result case), a stray low
      // surrogate, a bad hex digit, an unknown escape, a cut escape that beats the
      // held error, a cut frame and an empty string.
      add_row(8'h00, 1'b0, 1'b1, data_rsp(8'h00));
      add_row(8'hFF, 1'b0, 1'b1, data_rsp(8'hFF));
      add_u_rows(HIGH_SURR_HI, 1'b1);
      add_u_rows(LOW_SURR_HI, 1'b1);
      add_u_rows(HIGH_SURR_LO, 1'b1);
      add_u_rows(16'hFFFF, 1'b0);
      add_u_rows(LOW_SURR_LO, 1'b0);
      add_row(CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CH_U, 1'b0, 1'b0, '0);
      add_row(hex_char(4'd7, 1'b0), 1'b0, 1'b0, '0);
      add_row(8'h67, 1'b0, 1'b0, '0);
      add_row(CH_QUOTE, 1'b0, 1'b1, end_rsp(ST_BAD_UNICODE));
      add_row(CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(8'h71, 1'b0, 1'b0, '0);
      add_row(CH_BSLASH, 1'b1, 1'b1, end_rsp(ST_TRUNC_ESC));
      add_row(8'h78, 1'b1, 1'b1, end_rsp(ST_UNTERMINATED));
      add_row(CH_QUOTE, 1'b0, 1'b1, end_rsp(ST_OK));
      directed_count = directed_rows.size();

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].in_byte, directed_rows[i].eoi, directed_rows[i].typed,
                   directed_rows[i].want);

      // Random strings; start with the long hold-off while the sender keeps pushing.
      hold_pending = 1'b1;
      while (bytes_sent < directed_count + RANDOM_BYTES) begin
         if (bytes_sent < directed_count + RANDOM_BYTES - CALM_BYTES) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
         end else begin
            sender_idle = 1'b0;
            sink_idle   = 1'b0;
         end
         send_random_string();
      end
      req_ch.valid <= 1'b0;

      // Drain: wait for every owed result, then let the unit settle.
      while (utf8_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d body bytes (%0d scripted), checked %0d results.",
               bytes_sent, directed_count, results_seen);
      $display("Closed %0d strings, %0d of them with an error status.",
               strings_closed, strings_failed);
      if (mismatches == 0) begin
         $display("json_string_unescape_utf8_unit: match");
      end else begin
         $display("json_string_unescape_utf8_unit: mismatch");
      end
      $finish;
   end

endmodule
